// ----- rtl/core/mwmma_pkg.sv -----
// Shared types and constants for the multichannel window min/max/average block.
// Holds the request structs, the per-channel entry layout and the control state type.
// No dependencies.
package mwmma_pkg;

    localparam int CHANNELS      = 8;
    localparam int CH_W          = $clog2(CHANNELS);
    localparam int HISTORY_DEPTH = 8;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

    localparam logic [15:0] MIN_START = 16'h1000;

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW_SAMPLES = 2'd0;
    localparam logic [1:0] REG_AVERAGE_FACTOR = 2'd1;
    localparam logic [1:0] REG_AVERAGE_SHIFT  = 2'd2;
    localparam logic [1:0] REG_LAST_CHANNEL   = 2'd3;

    typedef struct packed {
        logic [2:0]         channel;
        logic signed [15:0] sample;
    } sample_req_t;

    typedef struct packed {
        logic [2:0]  out_channel;
        logic [15:0] window_max;
        logic [15:0] window_min;
        logic [15:0] window_average;
        logic [2:0]  history_slot;
        logic        history_full;
        logic        last_of_run;
    } result_req_t;

    typedef struct packed {
        logic [31:0] sum;
        logic [15:0] max;
        logic [15:0] min;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_CALC,
        ST_LOAD
    } state_t;

endpackage

// ----- rtl/core/mwmma_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Read during a write to the same address returns the old contents.
// No dependencies.
module mwmma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/multichannel_window_min_max_average.sv -----
// Top level of the multichannel window min/max/average block.
// Depends on mwmma_pkg (types, constants) and mwmma_ram (per-channel accumulator store).
//
//  channel   direction  handshake                      payload
//  sample    into       sample_valid / sample_stall    sample_req  (channel, sample)
//  result    out of     result_valid / result_stall    result_req  (window fields)
//  config    into       cfg_we                         cfg_index, cfg_data
//
// A sample that does not close a window reads its accumulator entry in the accept
// cycle and writes it back in the next, with a one-entry forward path covering
// back-to-back samples to the same channel. A sample that closes a window holds the
// input while it writes back; the block then sweeps channels 0..last_channel, each
// result passing through read, multiply and load steps, the load waiting while the
// result register is held by result_stall.
// Reset clears control state and marks every entry as cleared (valid bits), so no
// clearing pass is needed. Input is held off while a sweep runs.
module multichannel_window_min_max_average
    import mwmma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_req_t sample_req,

    output logic        result_valid,
    input  logic        result_stall,
    output result_req_t result_req,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [15:0] window_samples_reg;
    logic [15:0] average_factor_reg;
    logic [4:0]  average_shift_reg;
    logic [2:0]  last_channel_reg;

    // frame and ring tracking
    logic [15:0]       frame_count_reg;
    logic [SLOT_W-1:0] ring_index_reg;
    logic              ring_wrapped_reg;
    logic [SLOT_W-1:0] emit_slot_reg;
    logic              emit_full_reg;

    // update stage: sample waiting for its entry read data
    logic            st_valid_reg;
    logic [CH_W-1:0] st_ch_reg;
    logic [15:0]     st_mag_reg;
    logic            st_close_reg;

    // forward of the last written entry
    logic            fwd_valid_reg;
    logic [CH_W-1:0] fwd_ch_reg;
    entry_t          fwd_data_reg;

    logic [CHANNELS-1:0] entry_valid_reg;

    // sweep
    state_t          state_reg, state_next;
    logic [CH_W-1:0] sweep_ch_reg;
    logic [31:0]     prod_reg;
    logic [15:0]     sw_max_reg;
    logic [15:0]     sw_min_reg;

    logic        result_valid_reg;
    result_req_t result_req_reg;

    // memory port signals
    logic            ram_we;
    logic [CH_W-1:0] ram_raddr;
    entry_t          ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // control decode
    logic        accept;
    logic        in_range;
    logic        is_last;
    logic [15:0] frame_inc;
    logic        closes;
    logic [15:0] mag;
    logic        load_ok;

    entry_t cur_entry;
    entry_t upd_entry;
    entry_t sweep_entry;
    entry_t cleared_entry;

    assign cleared_entry = '{sum: 32'd0, max: 16'd0, min: MIN_START};

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign accept    = sample_valid && !sample_stall;
    assign in_range  = (sample_req.channel <= last_channel_reg)
                    && ({1'b0, sample_req.channel} < 4'(CHANNELS));
    assign is_last   = (sample_req.channel == last_channel_reg);
    assign frame_inc = frame_count_reg + 16'd1;
    assign closes    = in_range && is_last && (frame_inc == window_samples_reg);
    // two's complement magnitude; the most negative code maps to 0x8000
    assign mag       = sample_req.sample[15] ? (~sample_req.sample + 16'd1)
                                             : sample_req.sample;

    assign load_ok = !result_valid_reg || !result_stall;

    // ------------------------------------------------------------------
    // Read-modify-write of the accumulator entry
    // ------------------------------------------------------------------
    always_comb
    begin
        if (fwd_valid_reg && (fwd_ch_reg == st_ch_reg))
        begin
            cur_entry = fwd_data_reg;
        end
        else if (entry_valid_reg[st_ch_reg])
        begin
            cur_entry = entry_t'(ram_rdata);
        end
        else
        begin
            cur_entry = cleared_entry;
        end

        upd_entry     = cur_entry;
        upd_entry.sum = cur_entry.sum + {16'd0, st_mag_reg};
        if (st_mag_reg > cur_entry.max)
        begin
            upd_entry.max = st_mag_reg;
        end
        if (st_mag_reg < cur_entry.min)
        begin
            upd_entry.min = st_mag_reg;
        end
    end

    assign ram_we    = st_valid_reg;
    assign ram_wdata = upd_entry;

    assign sweep_entry = entry_valid_reg[sweep_ch_reg] ? entry_t'(ram_rdata) : cleared_entry;

    mwmma_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (st_ch_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                // closing sample writes back this cycle; sweep starts after it
                if (st_valid_reg && st_close_reg)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_ok)
                begin
                    state_next = (sweep_ch_reg == last_channel_reg) ? ST_RUN : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        sample_stall = 1'b1;
        ram_raddr    = sweep_ch_reg;
        case (state_reg)
            ST_RUN:
            begin
                // hold input while a window-closing sample is still in the update stage
                sample_stall = st_valid_reg && st_close_reg;
                ram_raddr    = sample_req.channel[CH_W-1:0];
            end
            ST_READ, ST_CALC, ST_LOAD:
            begin
                sample_stall = 1'b1;
                ram_raddr    = sweep_ch_reg;
            end
            default:
            begin
                sample_stall = 1'b1;
                ram_raddr    = sweep_ch_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_samples_reg <= 16'd128;
            average_factor_reg <= 16'd1;
            average_shift_reg  <= 5'd7;
            last_channel_reg   <= 3'd7;
            frame_count_reg    <= 16'd0;
            ring_index_reg     <= '0;
            ring_wrapped_reg   <= 1'b0;
            st_valid_reg       <= 1'b0;
            st_close_reg       <= 1'b0;
            fwd_valid_reg      <= 1'b0;
            entry_valid_reg    <= '0;
            state_reg          <= ST_RUN;
            sweep_ch_reg       <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_SAMPLES: window_samples_reg <= cfg_data;
                    REG_AVERAGE_FACTOR: average_factor_reg <= cfg_data;
                    REG_AVERAGE_SHIFT:  average_shift_reg  <= cfg_data[4:0];
                    REG_LAST_CHANNEL:   last_channel_reg   <= cfg_data[2:0];
                    default:            ;
                endcase
            end

            // advance the update stage; drop samples outside the frame
            st_valid_reg <= accept && in_range;
            st_close_reg <= accept && closes;

            if (accept && in_range && is_last)
            begin
                if (closes)
                begin
                    frame_count_reg <= 16'd0;
                    if (ring_index_reg == SLOT_W'(HISTORY_DEPTH - 1))
                    begin
                        ring_index_reg   <= '0;
                        ring_wrapped_reg <= 1'b1;
                    end
                    else
                    begin
                        ring_index_reg <= ring_index_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    frame_count_reg <= frame_inc;
                end
            end

            fwd_valid_reg <= st_valid_reg;
            if (st_valid_reg)
            begin
                entry_valid_reg[st_ch_reg] <= 1'b1;
            end

            // sweep: clear each channel as it is read out
            if (state_reg == ST_CALC)
            begin
                entry_valid_reg[sweep_ch_reg] <= 1'b0;
            end
            if (state_reg == ST_LOAD && load_ok)
            begin
                sweep_ch_reg <= (sweep_ch_reg == last_channel_reg) ? '0
                                                                    : sweep_ch_reg + CH_W'(1);
            end

            if (state_reg == ST_LOAD && load_ok)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_ch_reg  <= sample_req.channel[CH_W-1:0];
            st_mag_reg <= mag;
        end
        if (accept && closes)
        begin
            emit_slot_reg <= ring_index_reg;
            emit_full_reg <= ring_wrapped_reg
                          || (ring_index_reg == SLOT_W'(HISTORY_DEPTH - 1));
        end
        if (st_valid_reg)
        begin
            fwd_ch_reg   <= st_ch_reg;
            fwd_data_reg <= upd_entry;
        end
        if (state_reg == ST_CALC)
        begin
            prod_reg   <= (average_factor_reg > 16'd1)
                        ? 32'(sweep_entry.sum * {16'd0, average_factor_reg})
                        : sweep_entry.sum;
            sw_max_reg <= sweep_entry.max;
            sw_min_reg <= sweep_entry.min;
        end
        if (state_reg == ST_LOAD && load_ok)
        begin
            result_req_reg.out_channel    <= 3'(sweep_ch_reg);
            result_req_reg.window_max     <= sw_max_reg;
            result_req_reg.window_min     <= sw_min_reg;
            result_req_reg.window_average <= 16'(prod_reg >> average_shift_reg);
            result_req_reg.history_slot   <= 3'(emit_slot_reg);
            result_req_reg.history_full   <= emit_full_reg;
            result_req_reg.last_of_run    <= (sweep_ch_reg == last_channel_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign result_req   = result_req_reg;

endmodule

// ----- tb/sv/multichannel_window_min_max_average_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for multichannel_window_min_max_average.
// Holds a bit-accurate window predictor, a paced sample sender and a result checker.
// Depends on mwmma_pkg for the request structs, register indexes and sizes.
module multichannel_window_min_max_average_tb;
    import mwmma_pkg::*;

    localparam int RANDOM_ITEMS = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_CYCLES = 12;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef enum logic { RX_FREE, RX_CHOPPY } rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_req_t sample_req;
    logic        result_valid;
    logic        result_stall;
    result_req_t result_req;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    multichannel_window_min_max_average dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_req   (sample_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_req   (result_req),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the accumulators and registers
    // ------------------------------------------------------------------
    logic [31:0]       acc_sum [CHANNELS];
    logic [15:0]       acc_max [CHANNELS];
    logic [15:0]       acc_min [CHANNELS];
    logic [15:0]       frames_in_window;
    logic [SLOT_W-1:0] ring_slot;
    logic              ring_wrapped;
    logic [15:0]       cfg_window;
    logic [15:0]       cfg_factor;
    logic [4:0]        cfg_shift;
    logic [2:0]        cfg_last;

    result_req_t pending_windows [$];
    int          mismatch_count;

    rx_mode_t    receiver_mode;
    bit          long_hold_armed;
    int          burst_left;

    task automatic clear_channel_acc(int c);
        acc_sum[c] = '0;
        acc_max[c] = '0;
        acc_min[c] = MIN_START;
    endtask

    task automatic reset_predictor();
        for (int c = 0; c < CHANNELS; c++)
            clear_channel_acc(c);
        frames_in_window = '0;
        ring_slot        = '0;
        ring_wrapped     = 1'b0;
        cfg_window       = 16'd128;
        cfg_factor       = 16'd1;
        cfg_shift        = 5'd7;
        cfg_last         = 3'd7;
    endtask

    // Fold one accepted sample into the accumulators; on window close queue
    // one result per channel 0..last_channel.
    task automatic accumulate_sample(sample_req_t req);
        logic [15:0]       mag;
        logic [31:0]       scaled;
        logic [SLOT_W-1:0] slot;
        result_req_t       res;
        int                ch;
        ch = int'(req.channel);
        // drop channels outside the frame, they close nothing
        if (ch > int'(cfg_last) || ch >= CHANNELS)
            return;
        // magnitude; the most negative sample maps to 0x8000
        mag = req.sample[15] ? 16'(16'h0000 - req.sample) : req.sample;
        acc_sum[ch] = acc_sum[ch] + {16'd0, mag};
        if (mag > acc_max[ch]) acc_max[ch] = mag;
        if (mag < acc_min[ch]) acc_min[ch] = mag;
        if (ch != int'(cfg_last))
            return;
        // 16-bit wrapping frame counter, equality compare only
        frames_in_window = frames_in_window + 16'd1;
        if (frames_in_window != cfg_window)
            return;
        frames_in_window = frames_in_window - cfg_window;
        slot = ring_slot;
        if (int'(slot) + 1 >= HISTORY_DEPTH)
            ring_wrapped = 1'b1;
        ring_slot = SLOT_W'((int'(slot) + 1) % HISTORY_DEPTH);
        for (int c = 0; c <= int'(cfg_last) && c < CHANNELS; c++)
        begin
            scaled = acc_sum[c];
            if (cfg_factor > 16'd1)
                scaled = scaled * {16'd0, cfg_factor};
            scaled = scaled >> cfg_shift;
            res.out_channel    = 3'(c);
            res.window_max     = acc_max[c];
            res.window_min     = acc_min[c];
            res.window_average = scaled[15:0];
            res.history_slot   = slot;
            res.history_full   = ring_wrapped;
            res.last_of_run    = (c == int'(cfg_last));
            pending_windows.push_back(res);
            clear_channel_acc(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the time limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, plus one long hold when armed
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        int run_left;
        bit stall_on;
        bit stall_next;
        hold_left    = 0;
        run_left     = 0;
        stall_on     = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_armed)
            begin
                // count the hold here so the sender keeps offering meanwhile
                if (hold_left == 0)
                    hold_left = HOLD_CYCLES;
                hold_left--;
                stall_next = 1'b1;
                if (hold_left == 0)
                    long_hold_armed = 1'b0;
            end
            else if (receiver_mode == RX_FREE)
                stall_next = 1'b0;
            else
            begin
                if (run_left == 0)
                begin
                    stall_on = ($urandom_range(0, 99) < 35);
                    run_left = stall_on ? $urandom_range(1, 8) : $urandom_range(1, 16);
                end
                run_left--;
                stall_next = stall_on;
            end
            result_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest expected
    // ------------------------------------------------------------------
    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_req_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_windows.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual channel %0d",
                         $time, result_req.out_channel);
                mismatch_count++;
            end
            else
            begin
                want = pending_windows.pop_front();
                check_field("out_channel", 16'(want.out_channel), 16'(result_req.out_channel));
                check_field("window_max", want.window_max, result_req.window_max);
                check_field("window_min", want.window_min, result_req.window_min);
                check_field("window_average", want.window_average,
                            result_req.window_average);
                check_field("history_slot", 16'(want.history_slot),
                            16'(result_req.history_slot));
                check_field("history_full", 16'(want.history_full),
                            16'(result_req.history_full));
                check_field("last_of_run", 16'(want.last_of_run), 16'(result_req.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration helpers
    // ------------------------------------------------------------------

    // Offer one request and hold it until accepted, then predict.
    task automatic send_sample(logic [2:0] ch, logic [15:0] value);
        sample_req_t req;
        req.channel = ch;
        req.sample  = value;
        @(negedge clk);
        sample_valid <= 1'b1;
        sample_req   <= req;
        do
            @(posedge clk);
        while (sample_stall);
        accumulate_sample(req);
    endtask

    // Drop valid for the idle length n; scramble the idle payload.
    task automatic idle_sender(int n);
        sample_req_t junk;
        repeat (n)
        begin
            @(negedge clk);
            junk.channel = 3'($urandom);
            junk.sample  = 16'($urandom);
            sample_valid <= 1'b0;
            sample_req   <= junk;
        end
    endtask

    // Bursts of random length separated by random gaps.
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        idle_sender($urandom_range(1, 7));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
    endtask

    // Wait until every expected result is out, then let the block settle.
    task automatic wait_quiet();
        idle_sender(1);
        while (pending_windows.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            REG_WINDOW_SAMPLES: cfg_window = data;
            REG_AVERAGE_FACTOR: cfg_factor = data;
            REG_AVERAGE_SHIFT:  cfg_shift  = data[4:0];
            REG_LAST_CHANNEL:   cfg_last   = data[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [15:0] window, logic [15:0] factor,
                             logic [4:0] shift, logic [2:0] last);
        write_register(REG_WINDOW_SAMPLES, window);
        write_register(REG_AVERAGE_FACTOR, factor);
        // unused upper bits carry noise, the block must ignore them
        write_register(REG_AVERAGE_SHIFT, {11'($urandom), shift});
        write_register(REG_LAST_CHANNEL, {13'($urandom), last});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values of window, factor and shift: 128 frames of channel 0 only.
    task automatic test_reset_window();
        receiver_mode = RX_CHOPPY;
        write_register(REG_LAST_CHANNEL, 16'd0);
        repeat (128)
            send_sample(3'd0, 16'($urandom));
        wait_quiet();
    endtask

    // Field extremes, min threshold edges and both factor paths.
    task automatic test_extremes();
        logic [15:0] values [8];
        values = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                   16'h0001, 16'd4095, 16'd4096, 16'(-4097)};
        configure(16'd1, 16'd0, 5'd0, 3'd7);
        for (int c = 0; c < 8; c++)
            send_sample(3'(c), values[c]);
        wait_quiet();
        configure(16'd1, 16'hFFFF, 5'd0, 3'd7);
        for (int c = 0; c < 8; c++)
            send_sample(3'(c), values[7 - c]);
        wait_quiet();
    endtask

    // Channels past last_channel are dropped; out-of-order samples follow
    // their channel field.
    task automatic test_ignored_and_unordered();
        configure(16'd2, 16'd2, 5'd1, 3'd3);
        send_sample(3'd5, 16'h7000);
        send_sample(3'd0, 16'd100);
        send_sample(3'd2, 16'(-300));
        send_sample(3'd2, 16'd5000);
        send_sample(3'd7, 16'h8000);
        send_sample(3'd3, 16'd7);
        send_sample(3'd1, 16'd9000);
        send_sample(3'd0, 16'd1);
        send_sample(3'd3, 16'(-12));
        wait_quiet();
    endtask

    // Long receiver hold while the sender keeps offering: the block fills
    // and must stall its input without losing a result.
    task automatic test_backpressure();
        configure(16'd1, 16'd1, 5'd0, 3'd7);
        long_hold_armed = 1'b1;
        repeat (3)
            for (int c = 0; c < CHANNELS; c++)
                send_sample(3'(c), 16'($urandom));
        wait_quiet();
    endtask

    // Random phases of mostly well-formed frames with some stray channels.
    task automatic test_random_frames();
        int          accepted;
        int          pick;
        int          ch;
        logic [15:0] window;
        logic [15:0] factor;
        logic [4:0]  shift;
        logic [2:0]  last;
        accepted      = 0;
        receiver_mode = RX_CHOPPY;
        while (accepted < RANDOM_ITEMS)
        begin
            pick   = $urandom_range(0, 9);
            window = (pick < 6) ? 16'($urandom_range(1, 3)) :
                     (pick < 9) ? 16'($urandom_range(4, 8)) : 16'($urandom_range(9, 16));
            case ($urandom_range(0, 4))
                0:       factor = 16'd0;
                1:       factor = 16'd1;
                2:       factor = 16'hFFFF;
                3:       factor = 16'd2;
                default: factor = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       shift = 5'd0;
                1:       shift = 5'd31;
                default: shift = 5'($urandom);
            endcase
            last = ($urandom_range(0, 2) == 0) ? 3'd7 : 3'($urandom);
            configure(window, factor, shift, last);
            repeat ($urandom_range(2, 5))
                for (int c = 0; c <= int'(last); c++)
                begin
                    // occasionally break the frame with a stray channel
                    ch = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 7) : c;
                    send_sample(3'(ch), 16'($urandom));
                    accepted++;
                    pace_sender();
                end
            // close the open window so the next setting starts clean
            while (frames_in_window != 16'd0)
                for (int c = 0; c <= int'(last); c++)
                begin
                    send_sample(3'(c), 16'($urandom));
                    accepted++;
                    pace_sender();
                end
            wait_quiet();
        end
    endtask

    // Window shortened below the frame count: no window closes until the
    // count meets the register again.
    task automatic test_window_shortened();
        receiver_mode = RX_FREE;
        configure(16'd3, 16'd3, 5'd0, 3'd0);
        repeat (2)
            send_sample(3'd0, 16'($urandom));
        wait_quiet();
        write_register(REG_WINDOW_SAMPLES, 16'd1);
        repeat (5)
            send_sample(3'd0, 16'($urandom));
        wait_quiet();
        write_register(REG_WINDOW_SAMPLES, 16'd8);
        send_sample(3'd0, 16'($urandom));
        wait_quiet();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n           = 1'b0;
        sample_valid    = 1'b0;
        sample_req      = '0;
        cfg_we          = 1'b0;
        cfg_index       = REG_WINDOW_SAMPLES;
        cfg_data        = '0;
        mismatch_count  = 0;
        burst_left      = 0;
        long_hold_armed = 1'b0;
        receiver_mode   = RX_CHOPPY;
        reset_predictor();
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;

        test_reset_window();
        test_extremes();
        test_ignored_and_unordered();
        test_backpressure();
        test_random_frames();
        test_window_shortened();

        // drain, then keep watching for stray results after the queue is empty
        waited = 0;
        while (pending_windows.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20)
            @(posedge clk);
        if (pending_windows.size() != 0)
        begin
            $display("%0t: %0d results still expected, actual none",
                     $time, pending_windows.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- multichannel_window_min_max_average.f -----
rtl/core/mwmma_pkg.sv
rtl/core/mwmma_ram.sv
rtl/core/multichannel_window_min_max_average.sv
tb/sv/multichannel_window_min_max_average_tb.sv
